// ----- sv/ptsp_pkg.sv -----
package ptsp_pkg;

    // Parser phases, one per position in the rule grammar.
    typedef enum logic [4:0] {
        PH_NAME_START, PH_NAME_ALPHA, PH_NAME_QUOTED,
        PH_TIME_START, PH_NEED_HOUR, PH_HOUR, PH_NEED_MIN, PH_MIN, PH_NEED_SEC, PH_SEC,
        PH_AFTER_STD_TIME, PH_AFTER_DST_NAME, PH_EXPECT_COMMA1, PH_EXPECT_COMMA2,
        PH_RULE_START, PH_M_NEED_MON, PH_M_MON, PH_M_WEEK, PH_M_DOT2, PH_M_DAY,
        PH_DAY_DIGITS, PH_RULE_SLASH, PH_EXPECT_END, PH_DONE, PH_ERROR
    } t_phase;

    // Rule kinds.
    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_MONTH  = 2'd1;
    localparam logic [1:0] KIND_JULIAN = 2'd2;
    localparam logic [1:0] KIND_ZDAY   = 2'd3;

    localparam int HOUR_SECS         = 3600;
    localparam int DEFAULT_RULE_TIME = 2 * 3600;
    localparam int LAST_YDAY         = 365;
    localparam int MIN_NAME_CHARS    = 3;
    localparam int RES_DEPTH         = 4;

    typedef struct packed {
        logic [1:0]         kind;
        logic [8:0]         day;
        logic [2:0]         week;
        logic [6:0]         month;
        logic signed [22:0] rtime;
    } t_rule;

    // One result word.
    typedef struct packed {
        logic               rule_index;
        logic [47:0]        zone_name;
        logic [2:0]         name_length;
        logic signed [22:0] offset_seconds;
        logic [1:0]         rule_kind;
        logic [8:0]         rule_day;
        logic [2:0]         rule_week;
        logic [6:0]         rule_month;
        logic signed [22:0] rule_time;
        logic               valid_res;
        logic               last;
    } t_res;

    // Results produced by one accepted byte.
    typedef struct packed {
        logic [1:0] count;
        t_res       first;
        t_res       second;
    } t_emit;

endpackage

// ----- sv/ptsp_if.sv -----
interface ptsp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    modport source (output valid, output character, input ready);
    modport sink (input valid, input character, output ready);
endinterface

interface ptsp_rule_if;
    logic               valid;
    logic               ready;
    logic               rule_index;
    logic [47:0]        zone_name;
    logic [2:0]         name_length;
    logic signed [22:0] offset_seconds;
    logic [1:0]         rule_kind;
    logic [8:0]         rule_day;
    logic [2:0]         rule_week;
    logic [6:0]         rule_month;
    logic signed [22:0] rule_time;
    logic               valid_res;
    logic               last;
    modport source (output valid, output rule_index, output zone_name, output name_length,
                    output offset_seconds, output rule_kind, output rule_day,
                    output rule_week, output rule_month, output rule_time,
                    output valid_res, output last, input ready);
    modport sink (input valid, input rule_index, input zone_name, input name_length,
                  input offset_seconds, input rule_kind, input rule_day,
                  input rule_week, input rule_month, input rule_time,
                  input valid_res, input last, output ready);
endinterface

// ----- sv/ptsp_parse_core.sv -----
module ptsp_parse_core #(
    parameter int MAX_CHARS  = 63,
    parameter int NAME_CHARS = 6
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_character,
    output ptsp_pkg::t_emit o_emit
);
    import ptsp_pkg::*;

    localparam int NW  = 8 * NAME_CHARS;
    localparam int CW  = $clog2(NAME_CHARS + 1);
    localparam int CCW = $clog2(MAX_CHARS + 2);

    typedef struct packed {
        t_phase             ph;
        logic [1:0]         tgt;
        logic [NW-1:0]      nm0;
        logic [NW-1:0]      nm1;
        logic [CW-1:0]      nc0;
        logic [CW-1:0]      nc1;
        logic signed [22:0] off0;
        logic signed [22:0] off1;
        logic [21:0]        acc;
        logic [9:0]         fv;
        logic [1:0]         dc;
        logic               neg;
        t_rule              r0;
        t_rule              r1;
    } t_st;

    typedef struct packed {
        t_st  st;
        logic used;
    } t_step;

    t_st            r_st, n_st, w_st;
    logic [CCW-1:0] r_cc, n_cc;

    // Parser state at the start of a string.
    function automatic t_st start_state();
        t_st n;
        n    = '0;
        n.ph = PH_NAME_START;
        return n;
    endfunction

    // Start a signed h[:m[:s]] field.
    function automatic t_st enter_time(input t_st s);
        t_st n;
        n     = s;
        n.neg = 1'b0;
        n.acc = '0;
        n.fv  = '0;
        n.dc  = '0;
        n.ph  = PH_TIME_START;
        return n;
    endfunction

    // Decimal digit accumulation; callers keep the result below 1000.
    function automatic logic [9:0] acc10(input logic [9:0] v, input logic [3:0] d);
        logic [13:0] t;
        t = {4'd0, v} * 14'd10 + {10'd0, d};
        return t[9:0];
    endfunction

    // One parser step on one byte; used is low when the byte must be looked at again.
    function automatic t_step step(input t_st s, input logic [7:0] c);
        t_st                n;
        t_step              o;
        t_rule              r;
        logic               ri, dig, alp, used;
        logic [3:0]         d;
        logic [CW-1:0]      cnt;
        logic signed [22:0] v;
        n    = s;
        ri   = s.tgt[0];
        r    = ri ? s.r1 : s.r0;
        dig  = (c inside {["0":"9"]});
        alp  = (c inside {["A":"Z"], ["a":"z"]});
        d    = 4'(c - 8'd48);
        cnt  = ri ? s.nc1 : s.nc0;
        used = 1'b1;
        v    = '0;
        case (s.ph)
            PH_NAME_START: begin
                if (alp) begin
                    n.ph = PH_NAME_ALPHA;
                    used = 1'b0;
                end else if (c == "<") begin
                    n.ph = PH_NAME_QUOTED;
                end else begin
                    n.ph = PH_ERROR;
                end
            end
            PH_NAME_ALPHA, PH_NAME_QUOTED: begin
                if (alp || (s.ph == PH_NAME_QUOTED && (dig || c == "+" || c == "-"))) begin
                    // Append a name byte.
                    if (cnt >= CW'(NAME_CHARS)) begin
                        n.ph = PH_ERROR;
                    end else begin
                        for (int k = 0; k < NAME_CHARS; k++) begin
                            if (cnt == CW'(k)) begin
                                if (ri) n.nm1[8*k +: 8] = c;
                                else    n.nm0[8*k +: 8] = c;
                            end
                        end
                        if (ri) n.nc1 = cnt + CW'(1);
                        else    n.nc0 = cnt + CW'(1);
                    end
                end else if (s.ph == PH_NAME_QUOTED && c != ">") begin
                    n.ph = PH_ERROR;
                end else begin
                    // End of name.
                    used = (s.ph == PH_NAME_QUOTED);
                    if (cnt < CW'(MIN_NAME_CHARS)) begin
                        n.ph = PH_ERROR;
                        used = 1'b1;
                    end else if (s.tgt == 2'd0) begin
                        n = enter_time(n);
                    end else begin
                        n.ph = PH_AFTER_DST_NAME;
                    end
                end
            end
            PH_TIME_START: begin
                if (c == "+" || c == "-") begin
                    n.neg = (c == "-");
                    n.ph  = PH_NEED_HOUR;
                end else if (dig) begin
                    n.ph = PH_NEED_HOUR;
                    used = 1'b0;
                end else begin
                    n.ph = PH_ERROR;
                end
            end
            PH_NEED_HOUR, PH_NEED_MIN, PH_NEED_SEC: begin
                if (!dig) begin
                    n.ph = PH_ERROR;
                end else begin
                    n.fv = {6'd0, d};
                    n.dc = 2'd1;
                    if (s.ph == PH_NEED_HOUR)     n.ph = PH_HOUR;
                    else if (s.ph == PH_NEED_MIN) n.ph = PH_MIN;
                    else                          n.ph = PH_SEC;
                end
            end
            PH_HOUR, PH_MIN, PH_SEC: begin
                if (dig && ((s.ph == PH_HOUR && s.dc < 2'd3) || (s.ph != PH_HOUR && s.dc < 2'd2)))
                begin
                    n.fv = acc10(s.fv, d);
                    n.dc = s.dc + 2'd1;
                end else begin
                    if (s.ph == PH_HOUR)     n.acc = 22'({12'd0, s.fv} * 22'(HOUR_SECS));
                    else if (s.ph == PH_MIN) n.acc = s.acc + 22'({12'd0, s.fv} * 22'd60);
                    else                     n.acc = s.acc + {12'd0, s.fv};
                    if (s.ph == PH_HOUR && c == ":") begin
                        n.ph = PH_NEED_MIN;
                    end else if (s.ph == PH_MIN && c == ":") begin
                        n.ph = PH_NEED_SEC;
                    end else begin
                        // Field complete: store it where the target says.
                        used = 1'b0;
                        v    = s.neg ? -$signed({1'b0, n.acc}) : $signed({1'b0, n.acc});
                        if (s.tgt == 2'd0) begin
                            n.off0 = -v;
                            n.ph   = PH_AFTER_STD_TIME;
                        end else if (s.tgt == 2'd1) begin
                            n.off1 = -v;
                            n.ph   = PH_EXPECT_COMMA1;
                        end else begin
                            r.rtime = v;
                            n.ph    = (s.tgt == 2'd2) ? PH_EXPECT_COMMA2 : PH_EXPECT_END;
                        end
                    end
                end
            end
            PH_AFTER_STD_TIME: begin
                if (c == 8'd0) begin
                    n.ph = PH_DONE;
                end else begin
                    n.tgt = 2'd1;
                    n.ph  = PH_NAME_START;
                    used  = 1'b0;
                end
            end
            PH_AFTER_DST_NAME: begin
                used = 1'b0;
                if (dig || c == "+" || c == "-") begin
                    n = enter_time(n);
                end else begin
                    n.off1 = s.off0 + 23'(HOUR_SECS);
                    n.ph   = PH_EXPECT_COMMA1;
                end
            end
            PH_EXPECT_COMMA1, PH_EXPECT_COMMA2: begin
                if (c != ",") begin
                    n.ph = PH_ERROR;
                end else begin
                    n.tgt = (s.ph == PH_EXPECT_COMMA1) ? 2'd2 : 2'd3;
                    n.ph  = PH_RULE_START;
                end
            end
            PH_RULE_START: begin
                n.fv = '0;
                n.dc = '0;
                if (c == "M") begin
                    r.kind = KIND_MONTH;
                    n.ph   = PH_M_NEED_MON;
                end else if (c == "J") begin
                    r.kind = KIND_JULIAN;
                    n.ph   = PH_DAY_DIGITS;
                end else if (dig) begin
                    r.kind = KIND_ZDAY;
                    n.ph   = PH_DAY_DIGITS;
                    used   = 1'b0;
                end else begin
                    n.ph = PH_ERROR;
                end
            end
            PH_M_NEED_MON: begin
                if (!dig) begin
                    n.ph = PH_ERROR;
                end else begin
                    n.fv = {6'd0, d};
                    n.dc = 2'd1;
                    n.ph = PH_M_MON;
                end
            end
            PH_M_MON: begin
                if (c == ".") begin
                    r.month = s.fv[6:0];
                    n.ph    = PH_M_WEEK;
                end else if (dig && s.dc < 2'd2) begin
                    n.fv = acc10(s.fv, d);
                    n.dc = s.dc + 2'd1;
                end else begin
                    n.ph = PH_ERROR;
                end
            end
            PH_M_WEEK: begin
                if (c inside {["1":"5"]}) begin
                    r.week = d[2:0];
                    n.ph   = PH_M_DOT2;
                end else begin
                    n.ph = PH_ERROR;
                end
            end
            PH_M_DOT2: begin
                n.ph = (c == ".") ? PH_M_DAY : PH_ERROR;
            end
            PH_M_DAY: begin
                if (c inside {["0":"6"]}) begin
                    r.day = {5'd0, d};
                    n.ph  = PH_RULE_SLASH;
                end else begin
                    n.ph = PH_ERROR;
                end
            end
            PH_DAY_DIGITS: begin
                if (dig && s.dc < 2'd3) begin
                    n.fv = acc10(s.fv, d);
                    n.dc = s.dc + 2'd1;
                end else if ((r.kind == KIND_JULIAN && s.fv == 10'd0)
                             || s.fv > 10'(LAST_YDAY)) begin
                    n.ph = PH_ERROR;
                end else begin
                    r.day = s.fv[8:0];
                    n.ph  = PH_RULE_SLASH;
                    used  = 1'b0;
                end
            end
            PH_RULE_SLASH: begin
                if (c == "/") begin
                    n = enter_time(n);
                end else begin
                    r.rtime = 23'(DEFAULT_RULE_TIME);
                    n.ph    = (s.tgt == 2'd2) ? PH_EXPECT_COMMA2 : PH_EXPECT_END;
                    used    = 1'b0;
                end
            end
            PH_EXPECT_END: begin
                n.ph = (c == 8'd0) ? PH_DONE : PH_ERROR;
            end
            default: begin
                n.ph = PH_ERROR;
            end
        endcase
        if (ri) n.r1 = r;
        else    n.r0 = r;
        o.st   = n;
        o.used = used;
        return o;
    endfunction

    // Run the byte through the parser until a phase consumes it.
    always_comb begin
        t_step sv;
        logic  used;
        w_st = r_st;
        used = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (!used) begin
                sv   = step(w_st, i_character);
                w_st = sv.st;
                used = sv.used;
            end
        end
    end

    // Next state: length check, parse, and return to reset at the terminator.
    always_comb begin
        n_st = r_st;
        n_cc = r_cc;
        if (i_accept) begin
            if (i_character != 8'd0) begin
                if (r_cc <= CCW'(MAX_CHARS)) n_cc = r_cc + CCW'(1);
                if (n_cc > CCW'(MAX_CHARS)) n_st.ph = PH_ERROR;
                else                        n_st = w_st;
            end else begin
                n_st = start_state();
                n_cc = '0;
            end
        end
    end

    // Results at the terminator.
    always_comb begin
        logic [63:0] w0, w1;
        w0     = 64'(w_st.nm0);
        w1     = 64'(w_st.nm1);
        o_emit = '0;
        if (i_accept && i_character == 8'd0) begin
            if (w_st.ph == PH_DONE) begin
                o_emit.count                 = 2'd2;
                o_emit.first.rule_index      = 1'b0;
                o_emit.first.zone_name       = w0[47:0];
                o_emit.first.name_length     = 3'(w_st.nc0);
                o_emit.first.offset_seconds  = w_st.off0;
                o_emit.first.rule_kind       = w_st.r0.kind;
                o_emit.first.rule_day        = w_st.r0.day;
                o_emit.first.rule_week       = w_st.r0.week;
                o_emit.first.rule_month      = w_st.r0.month;
                o_emit.first.rule_time       = w_st.r0.rtime;
                o_emit.first.valid_res       = 1'b1;
                o_emit.second.rule_index     = 1'b1;
                o_emit.second.zone_name      = w1[47:0];
                o_emit.second.name_length    = 3'(w_st.nc1);
                o_emit.second.offset_seconds = w_st.off1;
                o_emit.second.rule_kind      = w_st.r1.kind;
                o_emit.second.rule_day       = w_st.r1.day;
                o_emit.second.rule_week      = w_st.r1.week;
                o_emit.second.rule_month     = w_st.r1.month;
                o_emit.second.rule_time      = w_st.r1.rtime;
                o_emit.second.valid_res      = 1'b1;
                o_emit.second.last           = 1'b1;
            end else begin
                o_emit.count      = 2'd1;
                o_emit.first.last = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= start_state();
            r_cc <= '0;
        end else begin
            r_st <= n_st;
            r_cc <= n_cc;
        end
    end

    // A terminator always returns the parser to the start of a string.
    a_term_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_character == 8'd0) |=> (r_st.ph == PH_NAME_START && r_cc == '0))
        else $error("parser not reset after terminator");
    // The character counter never runs past its saturation point.
    a_cc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cc <= CCW'(MAX_CHARS + 1))
        else $error("character counter overflow");
    // An overlong string always lands in the error phase.
    a_overlong: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cc > CCW'(MAX_CHARS)) |-> (r_st.ph == PH_ERROR))
        else $error("overlong string not flagged");

endmodule

// ----- sv/ptsp_res_fifo.sv -----
module ptsp_res_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ptsp_pkg::t_emit i_emit,
    output logic            o_room,
    output logic            o_valid,
    input  logic            i_ready,
    output ptsp_pkg::t_res  o_res
);
    import ptsp_pkg::*;

    localparam int PW = $clog2(RES_DEPTH);

    t_res          r_mem [RES_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt, n_cnt;
    logic          pop;

    // Room for a full pair of results keeps the parser from ever overrunning.
    assign o_room  = (r_cnt <= (PW+1)'(RES_DEPTH - 2));
    assign o_valid = (r_cnt != '0);
    assign o_res   = r_mem[r_rp];
    assign pop     = o_valid && i_ready;
    assign n_cnt   = r_cnt + (PW+1)'(i_emit.count) - (PW+1)'(pop);

    // Result storage.
    always_ff @(posedge i_clk) begin
        if (i_emit.count != 2'd0) r_mem[r_wp] <= i_emit.first;
        if (i_emit.count == 2'd2) r_mem[r_wp + PW'(1)] <= i_emit.second;
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + PW'(i_emit.count);
            r_rp  <= r_rp + PW'(pop);
            r_cnt <= n_cnt;
        end
    end

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (PW+1)'(RES_DEPTH))
        else $error("result queue over capacity");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_emit.count != 2'd0) |-> o_room)
        else $error("push without room");
    a_invalid_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_emit.count != 2'd0 && !i_emit.first.valid_res) |-> i_emit.first.last)
        else $error("invalid result not marked last");

endmodule

// ----- sv/posix_tz_rule_string_parser.sv -----
// POSIX TZ rule string parser.
// The i_char channel takes one byte of the rule string per word; a zero byte
// ends the string. The o_rule channel returns, for each string, either the
// standard-time and daylight-time results (the second marked last) or one
// result with valid_res low and last high.
// Throughput: one byte per cycle while i_char.ready is high. Each byte is
// parsed in the cycle it is accepted by a short chain of phase steps into the
// parser registers. The results of a string are written into the result
// queue when its zero byte is accepted and leave it on o_rule in order.
// Results wait in a four-entry queue. i_char.ready drops while the queue
// holds more than two results, so a stalled receiver holds back the input
// only after the queue has filled past two results; nothing is lost.
// Reset: the parser returns to the start of a string and the queue empties.
// Strings longer than MAX_CHARS bytes give the invalid result; names take
// 3 to NAME_CHARS characters.
module posix_tz_rule_string_parser #(
    parameter int MAX_CHARS  = 63,
    parameter int NAME_CHARS = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ptsp_char_if.sink   i_char,
    ptsp_rule_if.source o_rule
);
    import ptsp_pkg::*;

    t_emit emit;
    t_res  res;
    logic  room;

    assign i_char.ready = room;

    ptsp_parse_core #(
        .MAX_CHARS  (MAX_CHARS),
        .NAME_CHARS (NAME_CHARS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (i_char.valid && room),
        .i_character (i_char.character),
        .o_emit      (emit)
    );

    ptsp_res_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_emit  (emit),
        .o_room  (room),
        .o_valid (o_rule.valid),
        .i_ready (o_rule.ready),
        .o_res   (res)
    );

    // Result word onto the output channel.
    assign o_rule.rule_index     = res.rule_index;
    assign o_rule.zone_name      = res.zone_name;
    assign o_rule.name_length    = res.name_length;
    assign o_rule.offset_seconds = res.offset_seconds;
    assign o_rule.rule_kind      = res.rule_kind;
    assign o_rule.rule_day       = res.rule_day;
    assign o_rule.rule_week      = res.rule_week;
    assign o_rule.rule_month     = res.rule_month;
    assign o_rule.rule_time      = res.rule_time;
    assign o_rule.valid_res      = res.valid_res;
    assign o_rule.last           = res.last;

endmodule

// ----- tb/sv/ptsp_tb_if.sv -----
// The block's interfaces are defined with the RTL; this file only gives the
// testbench a shared bundle for one parsed rule, used by the predictor and the
// checker.
package ptsp_tb_pkg;
    import ptsp_pkg::*;

    // Expected rule word as the checker compares it.
    typedef struct {
        logic               rule_index;
        logic [47:0]        zone_name;
        logic [2:0]         name_length;
        logic signed [22:0] offset_seconds;
        logic [1:0]         rule_kind;
        logic [8:0]         rule_day;
        logic [2:0]         rule_week;
        logic [6:0]         rule_month;
        logic signed [22:0] rule_time;
        logic               valid_res;
        logic               last;
    } t_exp_rule;
endpackage

// ----- tb/sv/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ptsp_pkg::*;
    import ptsp_tb_pkg::*;

    localparam int MAX_STR   = 63;
    localparam int NAME_MAX  = 6;
    localparam int CYC_LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ptsp_char_if i_char ();
    ptsp_rule_if o_rule ();

    posix_tz_rule_string_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (i_char.sink),
        .o_rule  (o_rule.source)
    );

    always #10 i_clk = ~i_clk;

    // Parser model state.
    t_phase          ph;
    int unsigned     tgt;
    logic [47:0]     nm [2];
    int unsigned     ncnt [2];
    int              zoff [2];
    int unsigned     tacc, fval, dcnt;
    bit              neg, err;
    int unsigned     rkind [2], rday [2], rweek [2], rmon [2];
    int              rtim [2];
    int unsigned     ccount;

    byte unsigned    pending_chars [$];
    t_exp_rule       expected_rules [$];
    int              errors = 0;
    int              strings_sent = 0;
    int              bytes_sent = 0;
    int              words_seen = 0;
    int              invalid_seen = 0;
    longint          cycles = 0;
    bit              no_idle = 1'b0;

    function automatic bit is_dig(int unsigned c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_let(int unsigned c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic void parser_clear();
        ph = PH_NAME_START;
        tgt = 0;
        nm[0] = '0; nm[1] = '0;
        ncnt[0] = 0; ncnt[1] = 0;
        zoff[0] = 0; zoff[1] = 0;
        tacc = 0; fval = 0; dcnt = 0;
        neg = 0; err = 0; ccount = 0;
        for (int i = 0; i < 2; i++) begin
            rkind[i] = 0; rday[i] = 0; rweek[i] = 0; rmon[i] = 0; rtim[i] = 0;
        end
    endfunction

    function automatic void parse_fail();
        err = 1;
        ph = PH_ERROR;
    endfunction

    function automatic void time_begin();
        neg = 0; tacc = 0; fval = 0; dcnt = 0;
        ph = PH_TIME_START;
    endfunction

    function automatic void name_add(int unsigned c);
        int unsigned s;
        s = tgt & 1;
        if (ncnt[s] >= NAME_MAX) begin
            parse_fail();
            return;
        end
        nm[s][8*ncnt[s] +: 8] = c[7:0];
        ncnt[s]++;
    endfunction

    function automatic void name_close();
        if (ncnt[tgt & 1] < MIN_NAME_CHARS) begin
            parse_fail();
            return;
        end
        if (tgt == 0) time_begin();
        else ph = PH_AFTER_DST_NAME;
    endfunction

    function automatic void rule_close();
        ph = (tgt == 2) ? PH_EXPECT_COMMA2 : PH_EXPECT_END;
    endfunction

    function automatic void time_close();
        int v;
        v = neg ? -int'(tacc) : int'(tacc);
        if (tgt <= 1) begin
            zoff[tgt] = -v;
            ph = (tgt == 0) ? PH_AFTER_STD_TIME : PH_EXPECT_COMMA1;
        end else begin
            rtim[tgt & 1] = v;
            rule_close();
        end
    endfunction

    // One grammar step; returns 1 when the byte is consumed.
    function automatic bit parse_step(int unsigned c);
        int unsigned d, r;
        d = c - "0";
        r = tgt & 1;
        case (ph)
            PH_NAME_START: begin
                if (is_let(c)) begin ph = PH_NAME_ALPHA; return 0; end
                if (c == "<") begin ph = PH_NAME_QUOTED; return 1; end
                parse_fail(); return 1;
            end
            PH_NAME_ALPHA: begin
                if (is_let(c)) begin name_add(c); return 1; end
                name_close(); return 0;
            end
            PH_NAME_QUOTED: begin
                if (is_let(c) || is_dig(c) || c == "+" || c == "-") begin
                    name_add(c); return 1;
                end
                if (c == ">") name_close(); else parse_fail();
                return 1;
            end
            PH_TIME_START: begin
                if (c == "+" || c == "-") begin
                    neg = (c == "-"); ph = PH_NEED_HOUR; return 1;
                end
                if (is_dig(c)) begin ph = PH_NEED_HOUR; return 0; end
                parse_fail(); return 1;
            end
            PH_NEED_HOUR, PH_NEED_MIN, PH_NEED_SEC: begin
                if (!is_dig(c)) begin parse_fail(); return 1; end
                fval = d; dcnt = 1;
                ph = t_phase'(ph + 1);
                return 1;
            end
            PH_HOUR: begin
                if (is_dig(c) && dcnt < 3) begin fval = fval*10 + d; dcnt++; return 1; end
                tacc = fval * HOUR_SECS;
                if (c == ":") begin ph = PH_NEED_MIN; return 1; end
                time_close(); return 0;
            end
            PH_MIN: begin
                if (is_dig(c) && dcnt < 2) begin fval = fval*10 + d; dcnt++; return 1; end
                tacc += fval * 60;
                if (c == ":") begin ph = PH_NEED_SEC; return 1; end
                time_close(); return 0;
            end
            PH_SEC: begin
                if (is_dig(c) && dcnt < 2) begin fval = fval*10 + d; dcnt++; return 1; end
                tacc += fval;
                time_close(); return 0;
            end
            PH_AFTER_STD_TIME: begin
                if (c == 0) begin ph = PH_DONE; return 1; end
                tgt = 1; ph = PH_NAME_START;
                return 0;
            end
            PH_AFTER_DST_NAME: begin
                if (is_dig(c) || c == "+" || c == "-") begin time_begin(); return 0; end
                zoff[1] = zoff[0] + HOUR_SECS;
                ph = PH_EXPECT_COMMA1;
                return 0;
            end
            PH_EXPECT_COMMA1, PH_EXPECT_COMMA2: begin
                if (c != ",") begin parse_fail(); return 1; end
                tgt = (ph == PH_EXPECT_COMMA1) ? 2 : 3;
                ph = PH_RULE_START;
                return 1;
            end
            PH_RULE_START: begin
                fval = 0; dcnt = 0;
                if (c == "M") begin
                    rkind[r] = KIND_MONTH; ph = PH_M_NEED_MON; return 1;
                end
                if (c == "J") begin
                    rkind[r] = KIND_JULIAN; ph = PH_DAY_DIGITS; return 1;
                end
                if (is_dig(c)) begin
                    rkind[r] = KIND_ZDAY; ph = PH_DAY_DIGITS; return 0;
                end
                parse_fail(); return 1;
            end
            PH_M_NEED_MON: begin
                if (!is_dig(c)) begin parse_fail(); return 1; end
                fval = d; dcnt = 1; ph = PH_M_MON;
                return 1;
            end
            PH_M_MON: begin
                if (c == ".") begin rmon[r] = fval; ph = PH_M_WEEK; return 1; end
                if (is_dig(c) && dcnt < 2) begin fval = fval*10 + d; dcnt++; return 1; end
                parse_fail(); return 1;
            end
            PH_M_WEEK: begin
                if (c < "1" || c > "5") begin parse_fail(); return 1; end
                rweek[r] = d; ph = PH_M_DOT2;
                return 1;
            end
            PH_M_DOT2: begin
                if (c != ".") begin parse_fail(); return 1; end
                ph = PH_M_DAY;
                return 1;
            end
            PH_M_DAY: begin
                if (c < "0" || c > "6") begin parse_fail(); return 1; end
                rday[r] = d; ph = PH_RULE_SLASH;
                return 1;
            end
            PH_DAY_DIGITS: begin
                if (is_dig(c) && dcnt < 3) begin fval = fval*10 + d; dcnt++; return 1; end
                if (fval < ((rkind[r] == KIND_JULIAN) ? 1 : 0) || fval > LAST_YDAY) begin
                    parse_fail(); return 1;
                end
                rday[r] = fval; ph = PH_RULE_SLASH;
                return 0;
            end
            PH_RULE_SLASH: begin
                if (c == "/") begin time_begin(); return 1; end
                rtim[r] = DEFAULT_RULE_TIME;
                rule_close();
                return 0;
            end
            PH_EXPECT_END: begin
                if (c == 0) ph = PH_DONE; else parse_fail();
                return 1;
            end
            default: begin
                if (ph != PH_ERROR) parse_fail();
                return 1;
            end
        endcase
    endfunction

    function automatic t_exp_rule rule_word(int unsigned idx, bit ok, bit lst);
        t_exp_rule w;
        w = '{default: '0};
        if (ok) begin
            w.rule_index     = idx[0];
            w.zone_name      = nm[idx];
            w.name_length    = ncnt[idx][2:0];
            w.offset_seconds = zoff[idx][22:0];
            w.rule_kind      = rkind[idx][1:0];
            w.rule_day       = rday[idx][8:0];
            w.rule_week      = rweek[idx][2:0];
            w.rule_month     = rmon[idx][6:0];
            w.rule_time      = rtim[idx][22:0];
            w.valid_res      = 1'b1;
        end
        w.last = lst;
        return w;
    endfunction

    // Feeds one accepted byte to the parser model and queues any rule words.
    function automatic void predict_char(byte unsigned ch);
        int unsigned c;
        c = ch;
        if (c != 0) begin
            if (ccount <= MAX_STR) ccount++;
            if (ccount > MAX_STR) begin
                parse_fail();
                return;
            end
            for (int i = 0; i < 8; i++) if (parse_step(c)) break;
            return;
        end
        for (int i = 0; i < 8; i++) if (parse_step(0)) break;
        if (ph == PH_DONE && !err) begin
            expected_rules.push_back(rule_word(0, 1, 0));
            expected_rules.push_back(rule_word(1, 1, 1));
        end else begin
            expected_rules.push_back(rule_word(0, 0, 1));
        end
        parser_clear();
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH word %0d: %s got %0d expected %0d", words_seen, what, got, want);
        errors++;
    endtask

    // Stimulus helpers.
    function automatic void push_str(string s);
        for (int i = 0; i < s.len(); i++) pending_chars.push_back(s[i]);
        pending_chars.push_back(8'd0);
        strings_sent++;
        bytes_sent += s.len() + 1;
    endfunction

    function automatic string rnd_name();
        string s;
        int n;
        n = $urandom_range(100) < 90 ? $urandom_range(3, 6) : $urandom_range(1, 8);
        s = "";
        if ($urandom_range(3) == 0) begin
            for (int i = 0; i < n; i++) begin
                case ($urandom_range(3))
                    0: s = {s, string'(byte'("0" + $urandom_range(9)))};
                    1: s = {s, ($urandom_range(1) ? "+" : "-")};
                    default: s = {s, string'(byte'("A" + $urandom_range(25)))};
                endcase
            end
            return {"<", s, ">"};
        end
        for (int i = 0; i < n; i++)
            s = {s, string'(byte'(($urandom_range(1) ? "a" : "A") + $urandom_range(25)))};
        return s;
    endfunction

    function automatic string rnd_time();
        string s;
        int k;
        s = "";
        k = $urandom_range(3);
        if (k == 1) s = "+";
        if (k == 2) s = "-";
        s = {s, $sformatf("%0d", $urandom_range(100) < 80 ? $urandom_range(24)
                                                          : $urandom_range(999))};
        if ($urandom_range(1)) begin
            s = {s, $sformatf(":%02d", $urandom_range(99))};
            if ($urandom_range(1)) s = {s, $sformatf(":%0d", $urandom_range(99))};
        end
        return s;
    endfunction

    function automatic string rnd_rule();
        string s;
        case ($urandom_range(2))
            0: s = $sformatf("M%0d.%0d.%0d", $urandom_range(99), $urandom_range(1, 5),
                             $urandom_range(6));
            1: s = $sformatf("J%0d", $urandom_range(100) < 90 ? $urandom_range(1, 365)
                                                                : $urandom_range(999));
            default: s = $sformatf("%0d", $urandom_range(100) < 90 ? $urandom_range(365)
                                                                  : $urandom_range(999));
        endcase
        if ($urandom_range(1)) s = {s, "/", rnd_time()};
        return s;
    endfunction

    function automatic string mangle(string s);
        int p;
        if (s.len() == 0) return s;
        p = $urandom_range(s.len() - 1);
        s[p] = byte'($urandom_range(1, 255));
        return s;
    endfunction

    // Clock count and timeout.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // Byte driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_char.valid <= 1'b0;
            i_char.character <= 8'd0;
        end else if (!i_char.valid || i_char.ready) begin
            if (pending_chars.size() > 0 && (no_idle || $urandom_range(99) >= 38)) begin
                i_char.valid <= 1'b1;
                i_char.character <= pending_chars.pop_front();
            end else begin
                i_char.valid <= 1'b0;
            end
        end
    end

    // Receiver backpressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) o_rule.ready <= 1'b0;
        else o_rule.ready <= no_idle || ($urandom_range(99) >= 38);
    end

    // Prediction on accepted bytes and checking of accepted rule words.
    always @(posedge i_clk) begin
        t_exp_rule w;
        if (i_rst_n && i_char.valid && i_char.ready) predict_char(i_char.character);
        if (i_rst_n && o_rule.valid && o_rule.ready) begin
            words_seen++;
            if (expected_rules.size() == 0) begin
                report_mismatch("unexpected word, last", o_rule.last, 0);
            end else begin
                w = expected_rules.pop_front();
                if (!o_rule.valid_res) invalid_seen++;
                if (o_rule.valid_res !== w.valid_res)
                    report_mismatch("valid_res", o_rule.valid_res, w.valid_res);
                if (o_rule.last !== w.last) report_mismatch("last", o_rule.last, w.last);
                if (o_rule.rule_index !== w.rule_index)
                    report_mismatch("rule_index", o_rule.rule_index, w.rule_index);
                if (o_rule.zone_name !== w.zone_name)
                    report_mismatch("zone_name", o_rule.zone_name, w.zone_name);
                if (o_rule.name_length !== w.name_length)
                    report_mismatch("name_length", o_rule.name_length, w.name_length);
                if (o_rule.offset_seconds !== w.offset_seconds)
                    report_mismatch("offset_seconds", o_rule.offset_seconds,
                                    w.offset_seconds);
                if (o_rule.rule_kind !== w.rule_kind)
                    report_mismatch("rule_kind", o_rule.rule_kind, w.rule_kind);
                if (o_rule.rule_day !== w.rule_day)
                    report_mismatch("rule_day", o_rule.rule_day, w.rule_day);
                if (o_rule.rule_week !== w.rule_week)
                    report_mismatch("rule_week", o_rule.rule_week, w.rule_week);
                if (o_rule.rule_month !== w.rule_month)
                    report_mismatch("rule_month", o_rule.rule_month, w.rule_month);
                if (o_rule.rule_time !== w.rule_time)
                    report_mismatch("rule_time", o_rule.rule_time, w.rule_time);
            end
        end
    end

    initial begin
        string s, hi;
        parser_clear();
        i_char.valid = 1'b0;
        i_char.character = 8'd0;
        o_rule.ready = 1'b0;

        // Directed strings: plain zones, quoted names, each rule form, and errors.
        push_str("EST5");
        push_str("<+0330>-3:30:15");
        push_str("EST5EDT,M3.2.0,M11.1.0");
        push_str("CET-1CEST-2:00:00,M3.5.0/2,M10.5.0/-3:59:59");
        push_str("ABCDEF+999:59:59GHIJKL-999:59:59,J1/+999,J365/-999:59:59");
        push_str("<a1+-Z9>0<Q-1>,0/0,365/7");
        push_str("EST5EDT");
        push_str("");
        push_str("AB5");
        push_str("ABCDEFG5");
        push_str("<ABCDEFG>5");
        push_str("EST1234");
        push_str("EST5EDT,J0,J366");
        push_str("EST5EDT,M99.5.6,M0.1.0/12:345");
        push_str("EST\x805");
        hi = "";
        for (int i = 0; i < 8; i++) hi = {hi, string'(byte'(8'h80 + 16*i + i))};
        push_str({"UTC0", hi});
        s = "";
        for (int i = 0; i < 70; i++) s = {s, "A"};
        push_str(s);
        s = "ABC1DEF,M1.1.0,M2.2.0/";
        while (s.len() < MAX_STR) s = {s, "0"};
        push_str(s);

        // Random strings: mostly well formed, some mangled or pure noise.
        while (pending_chars.size() < 1350) begin
            case ($urandom_range(9))
                0: begin
                    s = "";
                    repeat ($urandom_range(1, 12))
                        s = {s, string'(byte'($urandom_range(1, 255)))};
                end
                1: s = {rnd_name(), rnd_time()};
                default: begin
                    s = {rnd_name(), rnd_time(), rnd_name()};
                    if ($urandom_range(1)) s = {s, rnd_time()};
                    s = {s, ",", rnd_rule(), ",", rnd_rule()};
                end
            endcase
            if ($urandom_range(9) == 0) s = mangle(s);
            push_str(s);
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // A stretch with no idling on either side.
        wait (pending_chars.size() < 900);
        @(posedge i_clk);
        no_idle <= 1'b1;
        wait (pending_chars.size() < 600);
        @(posedge i_clk);
        no_idle <= 1'b0;

        wait (pending_chars.size() == 0);
        @(posedge i_clk);
        wait (!i_char.valid);
        wait (expected_rules.size() == 0);
        repeat (20) @(posedge i_clk);

        $display("Ran %0d strings as %0d bytes; checked %0d rule words, %0d of them invalid.",
                 strings_sent, bytes_sent, words_seen, invalid_seen);
        if (errors == 0 && expected_rules.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
